/* src/blmc_pkg.sv */
`timescale 1ns / 1ps

package blmc_pkg;

	typedef logic [1:0] mode_t;

	localparam mode_t MODE_MANUAL = 2'd0;
	localparam mode_t MODE_FAST   = 2'd1;
	localparam mode_t MODE_SLOW   = 2'd2;

	localparam int REG_IDX_W = 3;
	typedef logic [REG_IDX_W-1:0] reg_idx_t;

	localparam reg_idx_t REG_DEBOUNCE_LIMIT   = 3'd0;
	localparam reg_idx_t REG_LONG_PRESS_TICKS = 3'd1;
	localparam reg_idx_t REG_FAST_HALF_PERIOD = 3'd2;
	localparam reg_idx_t REG_SLOW_ON_TICKS    = 3'd3;
	localparam reg_idx_t REG_SLOW_OFF_TICKS   = 3'd4;

	localparam int APB_ADDR_W = 5;
	localparam int APB_DATA_W = 32;

	localparam logic [7:0]  DEBOUNCE_LIMIT_RST   = 8'd20;
	localparam logic [15:0] LONG_PRESS_TICKS_RST = 16'd3000;
	localparam logic [15:0] FAST_HALF_PERIOD_RST = 16'd50;
	localparam logic [15:0] SLOW_ON_TICKS_RST    = 16'd100;
	localparam logic [15:0] SLOW_OFF_TICKS_RST   = 16'd900;

	typedef struct packed {
		logic  led_on;
		mode_t mode_now;
		logic  short_press;
		logic  long_press;
	} res_t;

	function automatic logic [15:0] sat_inc16(input logic [15:0] v);
		return (v == 16'hFFFF) ? v : v + 16'd1;
	endfunction

endpackage

/* src/blmc_if.sv */
`timescale 1ns / 1ps

interface blmc_in_if;
	logic valid;
	logic ready;
	logic button_level;

	modport source (output valid, output button_level, input ready);
	modport sink (input valid, input button_level, output ready);
endinterface

interface blmc_out_if;
	import blmc_pkg::*;

	logic  valid;
	logic  ready;
	logic  led_on;
	mode_t mode_now;
	logic  short_press;
	logic  long_press;

	modport source (output valid, output led_on, output mode_now, output short_press,
		output long_press, input ready);
	modport sink (input valid, input led_on, input mode_now, input short_press,
		input long_press, output ready);
endinterface

/* src/button_press_led_mode_controller.sv */
`timescale 1ns / 1ps

// Button press LED mode controller. Each item on tick is one millisecond sample of the raw
// button; each accepted item yields exactly one item on result, carrying the LED level, the
// mode and the short/long release pulses. One item is taken every clock cycle while tick's
// ready is high: all the debounce, hold timer and blink work is a single pass of logic
// between the state registers and the result register. A result register and one skid entry
// sit in front of result, so tick keeps its ready high while one result waits and drops it
// only when both entries are full. Registers on the APB port at byte address 4*i:
// 0 debounce_limit, 1 long_press_ticks, 2 fast_half_period, 3 slow_on_ticks,
// 4 slow_off_ticks; write them only while no item is in flight.
module button_press_led_mode_controller (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [blmc_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [blmc_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [blmc_pkg::APB_DATA_W-1:0]  prdata,
	output logic                             pready,
	blmc_in_if.sink                          tick,
	blmc_out_if.source                       result
);
	import blmc_pkg::*;

	// configuration
	logic [7:0]  debounce_limit_q;
	logic [15:0] long_press_ticks_q;
	logic [15:0] fast_half_period_q;
	logic [15:0] slow_on_ticks_q;
	logic [15:0] slow_off_ticks_q;

	// tick state
	logic [7:0]  debounce_count_q;
	logic        held_flag_q;
	logic [15:0] hold_duration_q;
	logic [15:0] blink_count_q;
	mode_t       mode_q;
	logic        led_q;

	// result register and skid entry
	res_t out_q;
	res_t skid_q;
	logic out_valid_q;
	logic skid_valid_q;

	logic     cfg_wr;
	reg_idx_t cfg_idx;
	logic     push;
	logic     pop;

	logic [7:0]  debounce_count_d;
	logic        held_flag_d;
	logic [15:0] hold_duration_d;
	logic [15:0] blink_count_d;
	mode_t       mode_d;
	logic        led_d;
	res_t        res_d;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_idx = paddr[APB_ADDR_W-1:2];

	always_comb begin
		unique case (cfg_idx)
			REG_DEBOUNCE_LIMIT:   prdata = {24'd0, debounce_limit_q};
			REG_LONG_PRESS_TICKS: prdata = {16'd0, long_press_ticks_q};
			REG_FAST_HALF_PERIOD: prdata = {16'd0, fast_half_period_q};
			REG_SLOW_ON_TICKS:    prdata = {16'd0, slow_on_ticks_q};
			REG_SLOW_OFF_TICKS:   prdata = {16'd0, slow_off_ticks_q};
			default:              prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_limit_q   <= DEBOUNCE_LIMIT_RST;
			long_press_ticks_q <= LONG_PRESS_TICKS_RST;
			fast_half_period_q <= FAST_HALF_PERIOD_RST;
			slow_on_ticks_q    <= SLOW_ON_TICKS_RST;
			slow_off_ticks_q   <= SLOW_OFF_TICKS_RST;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_DEBOUNCE_LIMIT:   debounce_limit_q   <= pwdata[7:0];
				REG_LONG_PRESS_TICKS: long_press_ticks_q <= pwdata[15:0];
				REG_FAST_HALF_PERIOD: fast_half_period_q <= pwdata[15:0];
				REG_SLOW_ON_TICKS:    slow_on_ticks_q    <= pwdata[15:0];
				REG_SLOW_OFF_TICKS:   slow_off_ticks_q   <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		logic press_ev;
		logic is_long;
		press_ev         = 1'b0;
		is_long          = 1'b0;
		debounce_count_d = debounce_count_q;
		held_flag_d      = held_flag_q;
		hold_duration_d  = hold_duration_q;
		blink_count_d    = blink_count_q;
		mode_d           = mode_q;
		led_d            = led_q;

		// up/down integrator, hold timer runs only at the ceiling
		if (tick.button_level) begin
			if (debounce_count_q < debounce_limit_q) begin
				debounce_count_d = debounce_count_q + 8'd1;
			end else begin
				held_flag_d     = 1'b1;
				hold_duration_d = sat_inc16(hold_duration_q);
			end
		end else if (debounce_count_q != 8'd0) begin
			debounce_count_d = debounce_count_q - 8'd1;
		end else if (held_flag_q) begin
			held_flag_d = 1'b0;
			press_ev    = 1'b1;
		end

		// blink timing of the current mode
		if (mode_q == MODE_FAST) begin
			blink_count_d = sat_inc16(blink_count_q);
			if (blink_count_d >= fast_half_period_q) begin
				led_d         = !led_q;
				blink_count_d = '0;
			end
		end else if (mode_q == MODE_SLOW) begin
			blink_count_d = sat_inc16(blink_count_q);
			if (!led_q && blink_count_d >= slow_off_ticks_q) begin
				led_d         = 1'b1;
				blink_count_d = '0;
			end else if (led_q && blink_count_d >= slow_on_ticks_q) begin
				led_d         = 1'b0;
				blink_count_d = '0;
			end
		end

		// release event after the blink update
		if (press_ev) begin
			is_long = hold_duration_q >= long_press_ticks_q;
			if (mode_q == MODE_MANUAL) begin
				if (!is_long) begin
					led_d = !led_d;
				end else begin
					mode_d        = MODE_FAST;
					blink_count_d = '0;
					led_d         = 1'b0;
				end
			end else if (mode_q == MODE_FAST) begin
				if (is_long) begin
					mode_d        = MODE_SLOW;
					blink_count_d = '0;
					led_d         = 1'b1;
				end
			end else if (mode_q == MODE_SLOW) begin
				if (is_long) begin
					mode_d = MODE_MANUAL;
					led_d  = 1'b1;
				end
			end
			hold_duration_d = '0;
		end

		res_d.led_on      = led_d;
		res_d.mode_now    = mode_d;
		res_d.short_press = press_ev && !is_long;
		res_d.long_press  = press_ev && is_long;
	end

	assign tick.ready = !skid_valid_q;
	assign push       = tick.valid && tick.ready;
	assign pop        = out_valid_q && result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_count_q <= '0;
			held_flag_q      <= 1'b0;
			hold_duration_q  <= '0;
			blink_count_q    <= '0;
			mode_q           <= MODE_MANUAL;
			led_q            <= 1'b1;
		end else if (push) begin
			debounce_count_q <= debounce_count_d;
			held_flag_q      <= held_flag_d;
			hold_duration_q  <= hold_duration_d;
			blink_count_q    <= blink_count_d;
			mode_q           <= mode_d;
			led_q            <= led_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				out_valid_q  <= skid_valid_q || push;
				skid_valid_q <= skid_valid_q && push;
			end else if (push) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= out_valid_q;
			end
		end
	end

	// payload needs no reset
	always_ff @(posedge clk) begin
		if (pop) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
				if (push) begin
					skid_q <= res_d;
				end
			end else if (push) begin
				out_q <= res_d;
			end
		end else if (push) begin
			if (!out_valid_q) begin
				out_q <= res_d;
			end else begin
				skid_q <= res_d;
			end
		end
	end

	assign result.valid       = out_valid_q;
	assign result.led_on      = out_q.led_on;
	assign result.mode_now    = out_q.mode_now;
	assign result.short_press = out_q.short_press;
	assign result.long_press  = out_q.long_press;

`ifndef SYNTH
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry held while result register empty");

	a_pulse_clears_held: assert property (@(posedge clk) disable iff (!arst_n)
		(push && (res_d.short_press || res_d.long_press)) |=> !held_flag_q)
		else $error("press pulse without held flag clearing");

	a_pulse_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !(res_d.short_press && res_d.long_press))
		else $error("short and long press in one item");

	a_mode_only_on_item: assert property (@(posedge clk) disable iff (!arst_n)
		!push |=> $stable(mode_q) && $stable(led_q))
		else $error("tick state changed without an accepted item");

	a_skid_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && skid_valid_q && !push) |=> (out_valid_q && !skid_valid_q))
		else $error("skid entry not moved to result register");
`endif

endmodule

/* tb/tb_button_press_led_mode_controller.sv */
`timescale 1ns / 1ps

module tb_button_press_led_mode_controller;
	import blmc_pkg::*;

	localparam int CLK_PERIOD = 4;
	localparam int RESET_CYCLES = 6;
	localparam int CYCLE_LIMIT = 400000;

	logic clk = 1'b0;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic pready;

	blmc_in_if tick_if ();
	blmc_out_if res_if ();

	button_press_led_mode_controller i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.tick    (tick_if),
		.result  (res_if)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// button levels waiting to be sent, and the results they will produce
	logic pending_levels[$];
	res_t due_results[$];

	int faults = 0;
	int unsigned cycles = 0;
	logic tick_taken = 1'b0;
	bit calm = 1'b0;
	bit sender_hold = 1'b0;

	// predictor settings and state
	logic [7:0]  cfg_debounce = DEBOUNCE_LIMIT_RST;
	logic [15:0] cfg_long = LONG_PRESS_TICKS_RST;
	logic [15:0] cfg_fast = FAST_HALF_PERIOD_RST;
	logic [15:0] cfg_on = SLOW_ON_TICKS_RST;
	logic [15:0] cfg_off = SLOW_OFF_TICKS_RST;

	logic [7:0]  deb_level = 8'd0;
	logic        held = 1'b0;
	logic [15:0] hold_len = 16'd0;
	logic [15:0] blink_len = 16'd0;
	mode_t       mode_cur = MODE_MANUAL;
	logic        led_cur = 1'b1;

	task automatic log_fault(input string what);
		if (faults < 10)
			$display("%0t: %s", $time, what);
		faults++;
	endtask

	task automatic predict_tick(input logic level, output res_t r);
		logic fire;
		logic is_long;
		fire = 1'b0;
		is_long = 1'b0;
		if (level) begin
			if (deb_level < cfg_debounce) begin
				deb_level = deb_level + 8'd1;
			end else begin
				held = 1'b1;
				if (hold_len != 16'hFFFF)
					hold_len = hold_len + 16'd1;
			end
		end else if (deb_level != 8'd0) begin
			deb_level = deb_level - 8'd1;
		end else if (held) begin
			held = 1'b0;
			fire = 1'b1;
		end

		// blink timing runs before the release is applied
		case (mode_cur)
			MODE_FAST: begin
				if (blink_len != 16'hFFFF)
					blink_len = blink_len + 16'd1;
				if (blink_len >= cfg_fast) begin
					led_cur = ~led_cur;
					blink_len = 16'd0;
				end
			end
			MODE_SLOW: begin
				if (blink_len != 16'hFFFF)
					blink_len = blink_len + 16'd1;
				if (led_cur ? (blink_len >= cfg_on) : (blink_len >= cfg_off)) begin
					led_cur = ~led_cur;
					blink_len = 16'd0;
				end
			end
			default: ;
		endcase

		if (fire) begin
			is_long = hold_len >= cfg_long;
			case (mode_cur)
				MODE_MANUAL: begin
					if (!is_long) begin
						led_cur = ~led_cur;
					end else begin
						mode_cur = MODE_FAST;
						blink_len = 16'd0;
						led_cur = 1'b0;
					end
				end
				MODE_FAST: begin
					if (is_long) begin
						mode_cur = MODE_SLOW;
						blink_len = 16'd0;
						led_cur = 1'b1;
					end
				end
				MODE_SLOW: begin
					if (is_long) begin
						mode_cur = MODE_MANUAL;
						led_cur = 1'b1;
					end
				end
				default: ;
			endcase
			hold_len = 16'd0;
		end

		r.led_on = led_cur;
		r.mode_now = mode_cur;
		r.short_press = fire && !is_long;
		r.long_press = fire && is_long;
	endtask

	// write a register, then read it back
	task automatic set_reg(input reg_idx_t idx, input logic [15:0] val);
		logic [APB_DATA_W-1:0] word;
		word = (idx == REG_DEBOUNCE_LIMIT) ? {24'd0, val[7:0]} : {16'd0, val};
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= word;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (prdata !== word)
			log_fault($sformatf("register %0d reads %0h, written %0h", idx, prdata, word));
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		case (idx)
			REG_DEBOUNCE_LIMIT:   cfg_debounce = val[7:0];
			REG_LONG_PRESS_TICKS: cfg_long = val;
			REG_FAST_HALF_PERIOD: cfg_fast = val;
			REG_SLOW_ON_TICKS:    cfg_on = val;
			REG_SLOW_OFF_TICKS:   cfg_off = val;
			default: ;
		endcase
	endtask

	task automatic settle();
		while (pending_levels.size() != 0 || tick_if.valid || due_results.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	// pressed for held ticks then released for rest ticks, each sample flipped
	// with a chance of bounce percent
	task automatic queue_press(input int held_ticks, input int rest, input int bounce);
		for (int k = 0; k < held_ticks; k++)
			pending_levels.push_back($urandom_range(99) >= bounce);
		for (int k = 0; k < rest; k++)
			pending_levels.push_back($urandom_range(99) < bounce);
	endtask

	task automatic random_settings();
		set_reg(REG_DEBOUNCE_LIMIT, 16'($urandom_range(0, 6)));
		set_reg(REG_LONG_PRESS_TICKS, 16'($urandom_range(1, 30)));
		set_reg(REG_FAST_HALF_PERIOD, 16'($urandom_range(1, 8)));
		set_reg(REG_SLOW_ON_TICKS, 16'($urandom_range(1, 8)));
		set_reg(REG_SLOW_OFF_TICKS, 16'($urandom_range(1, 12)));
	endtask

	// mostly clean presses of random length, some bouncing, some plain noise
	task automatic random_phase(input int n);
		int queued;
		int held_ticks;
		int rest;
		int bounce;
		queued = 0;
		while (queued < n) begin
			if ($urandom_range(99) < 80) begin
				held_ticks = cfg_debounce + $urandom_range(0, 2 * cfg_long + 3);
				rest = cfg_debounce + $urandom_range(1, 6);
				bounce = ($urandom_range(3) == 0) ? 10 : 0;
				queue_press(held_ticks, rest, bounce);
				queued += held_ticks + rest;
			end else begin
				held_ticks = $urandom_range(1, 10);
				queue_press(0, held_ticks, 50);
				queued += held_ticks;
			end
		end
	endtask

	// driver
	always @(negedge clk) begin
		if (arst_n && (tick_taken || !tick_if.valid)) begin
			if (!sender_hold && pending_levels.size() != 0
					&& (calm || $urandom_range(99) >= 21)) begin
				tick_if.valid <= 1'b1;
				tick_if.button_level <= pending_levels.pop_front();
			end else begin
				tick_if.valid <= 1'b0;
			end
		end
	end

	always @(negedge clk)
		res_if.ready <= calm || $urandom_range(99) >= 21;

	// monitor and checker
	always @(posedge clk) begin
		res_t want;
		res_t got;
		tick_taken <= tick_if.valid && tick_if.ready;
		if (arst_n) begin
			if (tick_if.valid && tick_if.ready) begin
				predict_tick(tick_if.button_level, want);
				due_results.push_back(want);
			end
			if (res_if.valid && res_if.ready) begin
				got.led_on = res_if.led_on;
				got.mode_now = res_if.mode_now;
				got.short_press = res_if.short_press;
				got.long_press = res_if.long_press;
				if (due_results.size() == 0) begin
					log_fault("result item with nothing expected");
				end else begin
					want = due_results.pop_front();
					if (got.led_on !== want.led_on || got.mode_now !== want.mode_now
							|| got.short_press !== want.short_press
							|| got.long_press !== want.long_press)
						log_fault($sformatf({"mismatch: expected led %0b mode %0d short %0b",
							" long %0b, got led %0b mode %0d short %0b long %0b"},
							want.led_on, want.mode_now, want.short_press, want.long_press,
							got.led_on, got.mode_now, got.short_press, got.long_press));
				end
			end
		end
	end

	always @(posedge clk)
		cycles <= cycles + 1;

	initial begin
		while (cycles < CYCLE_LIMIT) @(posedge clk);
		$display("tb_button_press_led_mode_controller: errors");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		tick_if.valid = 1'b0;
		tick_if.button_level = 1'b0;
		res_if.ready = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset settings: a tap far too short to pass the debouncer
		queue_press(1, 1, 0);
		settle();

		// zero everywhere: every press long, every blink compare true at once
		set_reg(REG_DEBOUNCE_LIMIT, 0);
		set_reg(REG_LONG_PRESS_TICKS, 0);
		set_reg(REG_FAST_HALF_PERIOD, 0);
		set_reg(REG_SLOW_ON_TICKS, 0);
		set_reg(REG_SLOW_OFF_TICKS, 0);
		repeat (3) queue_press(1, 2, 0);
		settle();

		set_reg(REG_LONG_PRESS_TICKS, 2);
		queue_press(1, 1, 0);
		queue_press(2, 1, 0);
		settle();

		// lower the limit under a charged integrator: still counts as held
		set_reg(REG_DEBOUNCE_LIMIT, 5);
		queue_press(4, 0, 0);
		settle();
		set_reg(REG_DEBOUNCE_LIMIT, 2);
		queue_press(1, 5, 0);
		settle();

		// no idling on either side for this stretch
		calm = 1'b1;
		random_settings();
		random_phase(160);
		settle();
		calm = 1'b0;

		set_reg(REG_DEBOUNCE_LIMIT, 0);
		set_reg(REG_LONG_PRESS_TICKS, 1);
		set_reg(REG_FAST_HALF_PERIOD, 1);
		set_reg(REG_SLOW_ON_TICKS, 1);
		set_reg(REG_SLOW_OFF_TICKS, 1);
		random_phase(160);
		settle();

		// sender stops mid-phase until the block has emptied
		random_settings();
		random_phase(160);
		while (pending_levels.size() > 60) @(posedge clk);
		sender_hold = 1'b1;
		while (due_results.size() != 0 || tick_if.valid) @(posedge clk);
		sender_hold = 1'b0;
		settle();

		random_settings();
		random_phase(160);
		settle();

		set_reg(REG_DEBOUNCE_LIMIT, 255);
		set_reg(REG_LONG_PRESS_TICKS, 16'hFFFF);
		set_reg(REG_FAST_HALF_PERIOD, 16'hFFFF);
		set_reg(REG_SLOW_ON_TICKS, 16'hFFFF);
		set_reg(REG_SLOW_OFF_TICKS, 16'hFFFF);
		queue_press(20, 20, 5);
		settle();

		repeat (8) @(posedge clk);
		faults += due_results.size();
		if (faults == 0)
			$display("tb_button_press_led_mode_controller: clean");
		else
			$display("tb_button_press_led_mode_controller: errors");
		$finish;
	end

endmodule
